// ===== rtl/core/mau_pkg.sv =====
package mau_pkg;

  localparam int unsigned QUAT_FRAC_BITS = 30;
  localparam int unsigned NEWTON_STEPS   = 2;
  localparam int unsigned ITER_W         = (NEWTON_STEPS > 2) ? 2 : 1;
  localparam int unsigned V_SHIFT        = 2 * QUAT_FRAC_BITS - 30;
  localparam int unsigned OUT_SHIFT      = 30 - QUAT_FRAC_BITS;
  localparam int unsigned QN_BASE_SHIFT  = 46 - QUAT_FRAC_BITS;

  localparam logic signed [63:0] Q30_ONE   = 64'sd1 <<< 30;
  localparam logic signed [63:0] QUAT_ONE  = 64'sd1 <<< QUAT_FRAC_BITS;
  localparam logic signed [63:0] HALF_MAX  = 64'sd1 <<< 28;
  localparam logic signed [63:0] NWT_THREE = 64'sd3 <<< 30;
  localparam logic signed [31:0] QUAT_OUT_ONE = 32'sd1073741824;

  localparam int unsigned MUL_DIGIT = 8;
  localparam int unsigned MUL_STEPS = 5;
  localparam int unsigned MUL_BW    = MUL_DIGIT * MUL_STEPS;
  localparam int unsigned OPB_W     = 34;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GYRO_SCALE     = 3'd0,
    CFG_PROP_GAIN      = 3'd1,
    CFG_INTEGRAL_GAIN  = 3'd2,
    CFG_INTEGRAL_LIMIT = 3'd3,
    CFG_HALF_STEP      = 3'd4
  } mau_cfg_e;

  typedef struct packed {
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } mau_in_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic               accel_valid;
  } mau_out_t;

  typedef struct packed {
    logic                     start;
    logic signed [63:0]       a;
    logic signed [OPB_W-1:0]  b;
  } mau_mul_req_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_NORM  = 5'b01000,
    ST_DONE  = 5'b10000
  } mau_state_e;

  typedef enum logic [3:0] {
    A_GS, A_AC, A_Q, A_AN, A_E, A_R, A_NQ, A_Y, A_M2
  } mau_asrc_e;

  typedef enum logic [3:0] {
    B_G, B_AC, B_Y, B_Q, B_V, B_KI, B_KP, B_HI, B_LO, B_H, B_NQ, B_Y2, B_F
  } mau_bsrc_e;

  typedef enum logic [1:0] {ACC_LOAD, ACC_LNEG, ACC_ADD, ACC_SUB} mau_acc_e;

  typedef enum logic [2:0] {PS_0, PS_2, PS_16, PS_30, PS_31, PS_32} mau_psh_e;

  typedef enum logic [3:0] {
    WB_NONE, WB_R, WB_Y2, WB_F, WB_Y, WB_AN, WB_V, WB_E, WB_I, WB_RC, WB_H, WB_NQ, WB_QN
  } mau_wb_e;

  typedef struct packed {
    mau_asrc_e  asrc;
    logic [1:0] aidx;
    mau_bsrc_e  bsrc;
    logic [1:0] bidx;
    mau_acc_e   acc;
    mau_psh_e   psh;
    mau_wb_e    wb;
    logic [1:0] widx;
  } mau_uop_t;

  localparam int unsigned PC_W = 6;
  localparam logic [PC_W-1:0] PC_S1_END  = 6'd5;
  localparam logic [PC_W-1:0] PC_AN      = 6'd6;
  localparam logic [PC_W-1:0] PC_H       = 6'd29;
  localparam logic [PC_W-1:0] PC_S2_END  = 6'd50;
  localparam logic [PC_W-1:0] PC_QN      = 6'd51;
  localparam logic [PC_W-1:0] PC_QN_END  = 6'd54;
  localparam logic [PC_W-1:0] PC_NWT     = 6'd55;
  localparam logic [PC_W-1:0] PC_NWT_END = 6'd57;

  function automatic mau_uop_t mk_uop(
    input mau_asrc_e as, input logic [1:0] ai, input mau_bsrc_e bs, input logic [1:0] bi,
    input mau_acc_e ac, input mau_psh_e ps, input mau_wb_e wb, input logic [1:0] wi);
    mau_uop_t u;
    u.asrc = as; u.aidx = ai; u.bsrc = bs; u.bidx = bi;
    u.acc  = ac; u.psh  = ps; u.wb   = wb; u.widx = wi;
    return u;
  endfunction

  function automatic mau_uop_t uop_rom(input logic [PC_W-1:0] pc);
    mau_uop_t u;
    unique case (pc)
      6'd0:  u = mk_uop(A_GS, 2'd0, B_G,  2'd0, ACC_LOAD, PS_2,  WB_R,    2'd0);
      6'd1:  u = mk_uop(A_GS, 2'd0, B_G,  2'd1, ACC_LOAD, PS_2,  WB_R,    2'd1);
      6'd2:  u = mk_uop(A_GS, 2'd0, B_G,  2'd2, ACC_LOAD, PS_2,  WB_R,    2'd2);
      6'd3:  u = mk_uop(A_AC, 2'd0, B_AC, 2'd0, ACC_LOAD, PS_0,  WB_NONE, 2'd0);
      6'd4:  u = mk_uop(A_AC, 2'd1, B_AC, 2'd1, ACC_ADD,  PS_0,  WB_NONE, 2'd0);
      6'd5:  u = mk_uop(A_AC, 2'd2, B_AC, 2'd2, ACC_ADD,  PS_0,  WB_NONE, 2'd0);
      6'd6:  u = mk_uop(A_AC, 2'd0, B_Y,  2'd0, ACC_LOAD, PS_0,  WB_AN,   2'd0);
      6'd7:  u = mk_uop(A_AC, 2'd1, B_Y,  2'd0, ACC_LOAD, PS_0,  WB_AN,   2'd1);
      6'd8:  u = mk_uop(A_AC, 2'd2, B_Y,  2'd0, ACC_LOAD, PS_0,  WB_AN,   2'd2);
      6'd9:  u = mk_uop(A_Q,  2'd1, B_Q,  2'd3, ACC_LOAD, PS_0,  WB_NONE, 2'd0);
      6'd10: u = mk_uop(A_Q,  2'd0, B_Q,  2'd2, ACC_SUB,  PS_0,  WB_V,    2'd0);
      6'd11: u = mk_uop(A_Q,  2'd0, B_Q,  2'd1, ACC_LOAD, PS_0,  WB_NONE, 2'd0);
      6'd12: u = mk_uop(A_Q,  2'd2, B_Q,  2'd3, ACC_ADD,  PS_0,  WB_V,    2'd1);
      6'd13: u = mk_uop(A_Q,  2'd0, B_Q,  2'd0, ACC_LOAD, PS_0,  WB_NONE, 2'd0);
      6'd14: u = mk_uop(A_Q,  2'd1, B_Q,  2'd1, ACC_SUB,  PS_0,  WB_NONE, 2'd0);
      6'd15: u = mk_uop(A_Q,  2'd2, B_Q,  2'd2, ACC_SUB,  PS_0,  WB_NONE, 2'd0);
      6'd16: u = mk_uop(A_Q,  2'd3, B_Q,  2'd3, ACC_ADD,  PS_0,  WB_V,    2'd2);
      6'd17: u = mk_uop(A_AN, 2'd1, B_V,  2'd2, ACC_LOAD, PS_0,  WB_NONE, 2'd0);
      6'd18: u = mk_uop(A_AN, 2'd2, B_V,  2'd1, ACC_SUB,  PS_0,  WB_E,    2'd0);
      6'd19: u = mk_uop(A_AN, 2'd2, B_V,  2'd0, ACC_LOAD, PS_0,  WB_NONE, 2'd0);
      6'd20: u = mk_uop(A_AN, 2'd0, B_V,  2'd2, ACC_SUB,  PS_0,  WB_E,    2'd1);
      6'd21: u = mk_uop(A_AN, 2'd0, B_V,  2'd1, ACC_LOAD, PS_0,  WB_NONE, 2'd0);
      6'd22: u = mk_uop(A_AN, 2'd1, B_V,  2'd0, ACC_SUB,  PS_0,  WB_E,    2'd2);
      6'd23: u = mk_uop(A_E,  2'd0, B_KI, 2'd0, ACC_LOAD, PS_32, WB_I,    2'd0);
      6'd24: u = mk_uop(A_E,  2'd0, B_KP, 2'd0, ACC_LOAD, PS_16, WB_RC,   2'd0);
      6'd25: u = mk_uop(A_E,  2'd1, B_KI, 2'd0, ACC_LOAD, PS_32, WB_I,    2'd1);
      6'd26: u = mk_uop(A_E,  2'd1, B_KP, 2'd0, ACC_LOAD, PS_16, WB_RC,   2'd1);
      6'd27: u = mk_uop(A_E,  2'd2, B_KI, 2'd0, ACC_LOAD, PS_32, WB_I,    2'd2);
      6'd28: u = mk_uop(A_E,  2'd2, B_KP, 2'd0, ACC_LOAD, PS_16, WB_RC,   2'd2);
      6'd29: u = mk_uop(A_R,  2'd0, B_HI, 2'd0, ACC_LOAD, PS_0,  WB_NONE, 2'd0);
      6'd30: u = mk_uop(A_R,  2'd0, B_LO, 2'd0, ACC_ADD,  PS_16, WB_H,    2'd0);
      6'd31: u = mk_uop(A_R,  2'd1, B_HI, 2'd0, ACC_LOAD, PS_0,  WB_NONE, 2'd0);
      6'd32: u = mk_uop(A_R,  2'd1, B_LO, 2'd0, ACC_ADD,  PS_16, WB_H,    2'd1);
      6'd33: u = mk_uop(A_R,  2'd2, B_HI, 2'd0, ACC_LOAD, PS_0,  WB_NONE, 2'd0);
      6'd34: u = mk_uop(A_R,  2'd2, B_LO, 2'd0, ACC_ADD,  PS_16, WB_H,    2'd2);
      6'd35: u = mk_uop(A_Q,  2'd1, B_H,  2'd0, ACC_LNEG, PS_0,  WB_NONE, 2'd0);
      6'd36: u = mk_uop(A_Q,  2'd2, B_H,  2'd1, ACC_SUB,  PS_0,  WB_NONE, 2'd0);
      6'd37: u = mk_uop(A_Q,  2'd3, B_H,  2'd2, ACC_SUB,  PS_0,  WB_NQ,   2'd0);
      6'd38: u = mk_uop(A_Q,  2'd0, B_H,  2'd0, ACC_LOAD, PS_0,  WB_NONE, 2'd0);
      6'd39: u = mk_uop(A_Q,  2'd2, B_H,  2'd2, ACC_ADD,  PS_0,  WB_NONE, 2'd0);
      6'd40: u = mk_uop(A_Q,  2'd3, B_H,  2'd1, ACC_SUB,  PS_0,  WB_NQ,   2'd1);
      6'd41: u = mk_uop(A_Q,  2'd0, B_H,  2'd1, ACC_LOAD, PS_0,  WB_NONE, 2'd0);
      6'd42: u = mk_uop(A_Q,  2'd1, B_H,  2'd2, ACC_SUB,  PS_0,  WB_NONE, 2'd0);
      6'd43: u = mk_uop(A_Q,  2'd3, B_H,  2'd0, ACC_ADD,  PS_0,  WB_NQ,   2'd2);
      6'd44: u = mk_uop(A_Q,  2'd0, B_H,  2'd2, ACC_LOAD, PS_0,  WB_NONE, 2'd0);
      6'd45: u = mk_uop(A_Q,  2'd1, B_H,  2'd1, ACC_ADD,  PS_0,  WB_NONE, 2'd0);
      6'd46: u = mk_uop(A_Q,  2'd2, B_H,  2'd0, ACC_SUB,  PS_0,  WB_NQ,   2'd3);
      6'd47: u = mk_uop(A_NQ, 2'd0, B_NQ, 2'd0, ACC_LOAD, PS_0,  WB_NONE, 2'd0);
      6'd48: u = mk_uop(A_NQ, 2'd1, B_NQ, 2'd1, ACC_ADD,  PS_0,  WB_NONE, 2'd0);
      6'd49: u = mk_uop(A_NQ, 2'd2, B_NQ, 2'd2, ACC_ADD,  PS_0,  WB_NONE, 2'd0);
      6'd50: u = mk_uop(A_NQ, 2'd3, B_NQ, 2'd3, ACC_ADD,  PS_0,  WB_NONE, 2'd0);
      6'd51: u = mk_uop(A_NQ, 2'd0, B_Y,  2'd0, ACC_LOAD, PS_0,  WB_QN,   2'd0);
      6'd52: u = mk_uop(A_NQ, 2'd1, B_Y,  2'd0, ACC_LOAD, PS_0,  WB_QN,   2'd1);
      6'd53: u = mk_uop(A_NQ, 2'd2, B_Y,  2'd0, ACC_LOAD, PS_0,  WB_QN,   2'd2);
      6'd54: u = mk_uop(A_NQ, 2'd3, B_Y,  2'd0, ACC_LOAD, PS_0,  WB_QN,   2'd3);
      6'd55: u = mk_uop(A_Y,  2'd0, B_Y,  2'd0, ACC_LOAD, PS_30, WB_Y2,   2'd0);
      6'd56: u = mk_uop(A_M2, 2'd0, B_Y2, 2'd0, ACC_LOAD, PS_30, WB_F,    2'd0);
      6'd57: u = mk_uop(A_Y,  2'd0, B_F,  2'd0, ACC_LOAD, PS_31, WB_Y,    2'd0);
      default: u = mk_uop(A_Y, 2'd0, B_Y, 2'd0, ACC_LOAD, PS_0, WB_NONE, 2'd0);
    endcase
    return u;
  endfunction

  function automatic logic [16:0] rsqrt_seed(input logic [3:0] idx);
    logic [16:0] s;
    unique case (idx)
      4'd0:  s = 17'd123576;
      4'd1:  s = 17'd111779;
      4'd2:  s = 17'd102821;
      4'd3:  s = 17'd95721;
      4'd4:  s = 17'd89915;
      4'd5:  s = 17'd85051;
      4'd6:  s = 17'd80899;
      4'd7:  s = 17'd77302;
      4'd8:  s = 17'd74146;
      4'd9:  s = 17'd71347;
      4'd10: s = 17'd68842;
      4'd11: s = 17'd66585;
      default: s = 17'd0;
    endcase
    return s;
  endfunction

  function automatic logic signed [63:0] sat(input logic signed [63:0] x,
                                             input logic signed [63:0] lim);
    logic signed [63:0] r;
    if (x > lim) begin
      r = lim;
    end else if (x < -lim) begin
      r = -lim;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mau_serial_mul.sv =====
module mau_serial_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mau_pkg::mau_mul_req_t req_i,
  output logic                 done_o,
  output logic signed [63:0]   prod_o
);
  import mau_pkg::*;

  logic signed [63:0]    a_q, a_d;
  logic [MUL_BW-1:0]     b_q, b_d;
  logic signed [63:0]    acc_q, acc_d;
  logic [2:0]            cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic signed [8:0]     dig;
  logic signed [72:0]    term;

  assign dig  = (cnt_q == 3'(MUL_STEPS - 1)) ? $signed({b_q[7], b_q[7:0]})
                                             : $signed({1'b0, b_q[7:0]});
  assign term = a_q * dig;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d    = req_i.a;
      b_d    = MUL_BW'(req_i.b);
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + term[63:0];
      a_d   = a_q <<< MUL_DIGIT;
      b_d   = b_q >> MUL_DIGIT;
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'(MUL_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== rtl/core/mau_rsqrt_norm.sv =====
module mau_rsqrt_norm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [63:0]       s_i,
  output logic              done_o,
  output logic [31:0]       m_o,
  output logic signed [5:0] k_o
);
  import mau_pkg::*;

  logic [63:0]       s_q, s_d;
  logic signed [5:0] k_q, k_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  always_comb begin
    s_d    = s_q;
    k_d    = k_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      s_d    = s_i;
      k_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      priority if (s_q[63:32] != '0) begin
        s_d = s_q >> 2;
        k_d = k_q - 6'sd1;
      end else if (s_q[31:30] == 2'b00) begin
        s_d = s_q << 2;
        k_d = k_q + 6'sd1;
      end else begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    k_q <= k_d;
  end

  assign done_o = done_q;
  assign m_o    = s_q[31:0];
  assign k_o    = k_q;

endmodule

// ===== rtl/core/mahony_attitude_update.sv =====
// Mahony attitude update: one gyro + accel sample in, one renormalized quaternion out.
// Input channel: in_valid_i / in_stall_o with in_data_i; a request is taken when
// valid is high and stall is low. Only one request is in flight at a time; in_stall_o
// is low whenever the sequencer is idle, even if the previous result is still waiting.
// Output channel: out_valid_o / out_stall_i with out_data_o. The result register holds
// its contents while out_stall_i is high; a new result loads when it frees.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i. Ready is
// always high; write only while no request is in progress.
// Datapath: every arithmetic step runs on one shared multiplier that consumes 8 bits
// of its second operand per cycle; each step is issued, multiplied and written back.
// A sample with nonzero acceleration takes 67 steps plus two normalization passes;
// a zero acceleration sample skips the correction and the first normalization pass.
// Reset: quaternion returns to identity, error integrals to zero, registers to their
// defaults, and both channels go idle.
module mahony_attitude_update (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  mau_pkg::mau_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output mau_pkg::mau_out_t          out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [mau_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                cfg_data_i
);
  import mau_pkg::*;

  logic [31:0] gyro_scale_q, prop_gain_q, integral_gain_q, half_step_q;
  logic [30:0] integral_limit_q;

  mau_state_e state_q, state_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic phase_q, phase_d;
  logic avalid_q, avalid_d;

  logic signed [63:0] t_q, t_d;
  logic signed [15:0] g_q [3], g_d [3];
  logic signed [15:0] ac_q [3], ac_d [3];
  logic signed [47:0] r_q [3], r_d [3];
  logic signed [31:0] an_q [3], an_d [3];
  logic signed [31:0] v_q [3], v_d [3];
  logic signed [31:0] e_q [3], e_d [3];
  logic signed [31:0] h_q [3], h_d [3];
  logic signed [31:0] integ_q [3], integ_d [3];
  logic signed [31:0] q_q [4], q_d [4];
  logic signed [OPB_W-1:0] nq_q [4], nq_d [4];
  logic signed [OPB_W-1:0] y_q, y_d, y2_q, y2_d, f_q, f_d;

  logic     out_valid_q, out_valid_d;
  mau_out_t out_data_q, out_data_d;

  mau_uop_t           uop;
  mau_mul_req_t       mul_req;
  logic               mul_done;
  logic signed [63:0] prod;
  logic signed [63:0] op_a;
  logic signed [OPB_W-1:0] op_b;
  logic signed [63:0] ps;
  logic signed [63:0] t_new;

  logic               norm_start;
  logic               norm_done;
  logic [31:0]        norm_m;
  logic signed [5:0]  norm_k;

  assign uop = uop_rom(pc_q);

  always_comb begin
    unique case (uop.asrc)
      A_GS:    op_a = $signed({32'd0, gyro_scale_q});
      A_AC:    op_a = 64'(ac_q[uop.aidx]);
      A_Q:     op_a = 64'(q_q[uop.aidx]);
      A_AN:    op_a = 64'(an_q[uop.aidx]);
      A_E:     op_a = 64'(e_q[uop.aidx]);
      A_R:     op_a = 64'(r_q[uop.aidx]);
      A_NQ:    op_a = 64'(nq_q[uop.aidx]);
      A_Y:     op_a = 64'(y_q);
      A_M2:    op_a = $signed({34'd0, norm_m[31:2]});
      default: op_a = '0;
    endcase
    unique case (uop.bsrc)
      B_G:     op_b = OPB_W'(g_q[uop.bidx]);
      B_AC:    op_b = OPB_W'(ac_q[uop.bidx]);
      B_Y:     op_b = y_q;
      B_Q:     op_b = OPB_W'(q_q[uop.bidx]);
      B_V:     op_b = OPB_W'(v_q[uop.bidx]);
      B_KI:    op_b = $signed({2'b00, integral_gain_q});
      B_KP:    op_b = $signed({2'b00, prop_gain_q});
      B_HI:    op_b = $signed({18'd0, half_step_q[31:16]});
      B_LO:    op_b = $signed({18'd0, half_step_q[15:0]});
      B_H:     op_b = OPB_W'(h_q[uop.bidx]);
      B_NQ:    op_b = nq_q[uop.bidx];
      B_Y2:    op_b = y2_q;
      B_F:     op_b = f_q;
      default: op_b = '0;
    endcase
  end

  always_comb begin
    unique case (uop.psh)
      PS_0:    ps = prod;
      PS_2:    ps = prod >>> 2;
      PS_16:   ps = prod >>> 16;
      PS_30:   ps = prod >>> 30;
      PS_31:   ps = prod >>> 31;
      PS_32:   ps = prod >>> 32;
      default: ps = prod;
    endcase
    unique case (uop.acc)
      ACC_LOAD: t_new = ps;
      ACC_LNEG: t_new = -ps;
      ACC_ADD:  t_new = t_q + ps;
      ACC_SUB:  t_new = t_q - ps;
      default:  t_new = ps;
    endcase
  end

  mau_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (prod)
  );

  mau_rsqrt_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .s_i     (t_new),
    .done_o  (norm_done),
    .m_o     (norm_m),
    .k_o     (norm_k)
  );

  always_comb begin
    logic [6:0]          shamt;
    logic signed [63:0]  fnum;
    logic signed [33:0]  isum;
    logic signed [63:0]  lim64;

    state_d  = state_q;
    pc_d     = pc_q;
    iter_d   = iter_q;
    phase_d  = phase_q;
    avalid_d = avalid_q;
    t_d      = t_q;
    g_d      = g_q;
    ac_d     = ac_q;
    r_d      = r_q;
    an_d     = an_q;
    v_d      = v_q;
    e_d      = e_q;
    h_d      = h_q;
    integ_d  = integ_q;
    q_d      = q_q;
    nq_d     = nq_q;
    y_d      = y_q;
    y2_d     = y2_q;
    f_d      = f_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    mul_req.start = 1'b0;
    mul_req.a     = op_a;
    mul_req.b     = op_b;
    norm_start    = 1'b0;
    shamt = '0;
    fnum  = NWT_THREE - t_new;
    isum  = 34'(integ_q[uop.widx]) + $signed(t_new[33:0]);
    lim64 = $signed({33'd0, integral_limit_q});

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          g_d[0]  = in_data_i.gyro_x;
          g_d[1]  = in_data_i.gyro_y;
          g_d[2]  = in_data_i.gyro_z;
          ac_d[0] = in_data_i.accel_x;
          ac_d[1] = in_data_i.accel_y;
          ac_d[2] = in_data_i.accel_z;
          pc_d    = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        mul_req.start = 1'b1;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          t_d = t_new;
          unique case (uop.wb)
            WB_NONE: ;
            WB_R:  r_d[uop.widx] = t_new[47:0];
            WB_Y2: y2_d = t_new[OPB_W-1:0];
            WB_F:  f_d  = (fnum < 0) ? '0 : fnum[OPB_W-1:0];
            WB_Y:  y_d  = t_new[OPB_W-1:0];
            WB_AN: begin
              shamt = 7'sd16 - 7'(norm_k);
              an_d[uop.widx] = 32'(sat(t_new >>> shamt, Q30_ONE));
            end
            WB_V:  v_d[uop.widx] = 32'(sat(((uop.widx == 2'd2) ? t_new : (t_new <<< 1))
                                           >>> V_SHIFT, Q30_ONE));
            WB_E:  e_d[uop.widx] = 32'(sat(t_new >>> 30, Q30_ONE));
            WB_I:  integ_d[uop.widx] = 32'(sat(64'(isum), lim64));
            WB_RC: r_d[uop.widx] = r_q[uop.widx] + t_new[47:0]
                                   + 48'(integ_q[uop.widx]);
            WB_H:  h_d[uop.widx] = 32'(sat(t_new >>> 16, HALF_MAX));
            WB_NQ: begin
              t_d = t_new >>> 30;
              nq_d[uop.widx] = OPB_W'(q_q[uop.widx]) + t_d[OPB_W-1:0];
            end
            WB_QN: begin
              shamt = 7'(QN_BASE_SHIFT) - 7'(norm_k);
              q_d[uop.widx] = 32'(sat(t_new >>> shamt, QUAT_ONE));
            end
            default: ;
          endcase

          priority if (pc_q == PC_S1_END) begin
            if (t_new == '0) begin
              avalid_d = 1'b0;
              pc_d     = PC_H;
              state_d  = ST_ISSUE;
            end else begin
              avalid_d   = 1'b1;
              phase_d    = 1'b0;
              norm_start = 1'b1;
              state_d    = ST_NORM;
            end
          end else if (pc_q == PC_S2_END) begin
            if (t_new == '0) begin
              q_d[0]  = 32'(QUAT_ONE);
              q_d[1]  = '0;
              q_d[2]  = '0;
              q_d[3]  = '0;
              state_d = ST_DONE;
            end else begin
              phase_d    = 1'b1;
              norm_start = 1'b1;
              state_d    = ST_NORM;
            end
          end else if (pc_q == PC_NWT_END) begin
            if (iter_q == ITER_W'(NEWTON_STEPS - 1)) begin
              pc_d = phase_q ? PC_QN : PC_AN;
            end else begin
              iter_d = iter_q + 1'b1;
              pc_d   = PC_NWT;
            end
            state_d = ST_ISSUE;
          end else if (pc_q == PC_QN_END) begin
            state_d = ST_DONE;
          end else begin
            pc_d    = pc_q + 1'b1;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_NORM: begin
        if (norm_done) begin
          y_d     = OPB_W'({rsqrt_seed(4'(norm_m[31:28] - 4'd4)), 14'd0});
          iter_d  = '0;
          pc_d    = PC_NWT;
          state_d = ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_data_d.quat_w      = q_q[0] <<< OUT_SHIFT;
          out_data_d.quat_x      = q_q[1] <<< OUT_SHIFT;
          out_data_d.quat_y      = q_q[2] <<< OUT_SHIFT;
          out_data_d.quat_z      = q_q[3] <<< OUT_SHIFT;
          out_data_d.accel_valid = avalid_q;
          state_d                = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_scale_q     <= 32'd572220;
      prop_gain_q      <= 32'd131072;
      integral_gain_q  <= 32'd0;
      integral_limit_q <= 31'd536870912;
      half_step_q      <= 32'd21474836;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GYRO_SCALE:     gyro_scale_q     <= cfg_data_i;
        CFG_PROP_GAIN:      prop_gain_q      <= cfg_data_i;
        CFG_INTEGRAL_GAIN:  integral_gain_q  <= cfg_data_i;
        CFG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data_i[30:0];
        CFG_HALF_STEP:      half_step_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      iter_q      <= '0;
      phase_q     <= 1'b0;
      avalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      q_q[0]      <= 32'(QUAT_ONE);
      q_q[1]      <= '0;
      q_q[2]      <= '0;
      q_q[3]      <= '0;
      integ_q[0]  <= '0;
      integ_q[1]  <= '0;
      integ_q[2]  <= '0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      iter_q      <= iter_d;
      phase_q     <= phase_d;
      avalid_q    <= avalid_d;
      out_valid_q <= out_valid_d;
      q_q         <= q_d;
      integ_q     <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    g_q        <= g_d;
    ac_q       <= ac_d;
    r_q        <= r_d;
    an_q       <= an_d;
    v_q        <= v_d;
    e_q        <= e_d;
    h_q        <= h_d;
    nq_q       <= nq_d;
    y_q        <= y_d;
    y2_q       <= y2_d;
    f_q        <= f_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

endmodule

// ===== rtl/core/mau_checker.sv =====
module mau_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input mau_pkg::mau_out_t out_data_o
);
  import mau_pkg::*;

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled while a request is in progress");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in progress");

  a_quat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.quat_w <= QUAT_OUT_ONE && out_data_o.quat_w >= -QUAT_OUT_ONE
                  && out_data_o.quat_x <= QUAT_OUT_ONE && out_data_o.quat_x >= -QUAT_OUT_ONE
                  && out_data_o.quat_y <= QUAT_OUT_ONE && out_data_o.quat_y >= -QUAT_OUT_ONE
                  && out_data_o.quat_z <= QUAT_OUT_ONE && out_data_o.quat_z >= -QUAT_OUT_ONE))
    else $error("quaternion component out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind mahony_attitude_update mau_checker u_mau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== bench/tb_mahony_attitude_update.sv =====
`timescale 1ns / 1ps

module tb_mahony_attitude_update;
  import mau_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int DRAIN_CYCLES = 600;

  localparam logic [31:0] SEED_TAB [12] = '{
    123576, 111779, 102821, 95721, 89915, 85051,
    80899, 77302, 74146, 71347, 68842, 66585
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  mau_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  mau_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  mahony_attitude_update uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  logic [31:0] gyro_scale_r, prop_gain_r, int_gain_r, int_limit_r, half_step_r;
  logic signed [31:0] att_q [4];
  logic signed [31:0] err_int [3];

  mau_in_t pending_samples [$];
  mau_out_t expected_quats [$];
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  bit hold_input = 1'b0;
  int errors = 0;
  int n_results = 0;
  int n_no_accel = 0;
  int cycles = 0;

  function automatic logic signed [63:0] clip(input logic signed [63:0] x,
                                              input logic signed [63:0] lo,
                                              input logic signed [63:0] hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic logic signed [63:0] inv_root(input logic [63:0] s, output int k);
    logic signed [63:0] m, y, y2, t, f;
    k = 0;
    while (s >= 64'h1_0000_0000) begin
      s = s >> 2;
      k--;
    end
    while (s < 64'h4000_0000) begin
      s = s << 2;
      k++;
    end
    m = $signed(s);
    y = $signed({32'b0, SEED_TAB[(m >>> 28) - 4]}) <<< 14;
    for (int i = 0; i < NEWTON_STEPS; i++) begin
      y2 = (y * y) >>> 30;
      t = ((m >>> 2) * y2) >>> 30;
      f = (64'sd3 <<< 30) - t;
      if (f < 0) f = 0;
      y = (y * f) >>> 31;
    end
    return y;
  endfunction

  function automatic mau_out_t predict_quat(input mau_in_t smp);
    logic signed [63:0] g[3], a[3], r[3], h[3], q[4], nq[4], an[3], v[3], e[3];
    logic signed [63:0] y, acc, t, hi, lo, lim, one;
    logic [63:0] s;
    int k;
    mau_out_t o;
    one = 64'sd1 <<< 30;
    hi = $signed({48'b0, half_step_r[31:16]});
    lo = $signed({48'b0, half_step_r[15:0]});
    lim = $signed({32'b0, int_limit_r});
    g[0] = smp.gyro_x; g[1] = smp.gyro_y; g[2] = smp.gyro_z;
    a[0] = smp.accel_x; a[1] = smp.accel_y; a[2] = smp.accel_z;
    for (int i = 0; i < 3; i++) r[i] = (g[i] * $signed({32'b0, gyro_scale_r})) >>> 2;
    for (int i = 0; i < 4; i++) q[i] = att_q[i];
    s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    o.accel_valid = (s != 0);
    if (s != 0) begin
      y = inv_root(s, k);
      for (int i = 0; i < 3; i++) an[i] = clip((a[i] * y) >>> (16 - k), -one, one);
      v[0] = (2 * (q[1] * q[3] - q[0] * q[2])) >>> V_SHIFT;
      v[1] = (2 * (q[0] * q[1] + q[2] * q[3])) >>> V_SHIFT;
      v[2] = (q[0] * q[0] - q[1] * q[1] - q[2] * q[2] + q[3] * q[3]) >>> V_SHIFT;
      for (int i = 0; i < 3; i++) v[i] = clip(v[i], -one, one);
      e[0] = (an[1] * v[2] - an[2] * v[1]) >>> 30;
      e[1] = (an[2] * v[0] - an[0] * v[2]) >>> 30;
      e[2] = (an[0] * v[1] - an[1] * v[0]) >>> 30;
      for (int i = 0; i < 3; i++) begin
        e[i] = clip(e[i], -one, one);
        acc = err_int[i] + ((e[i] * $signed({32'b0, int_gain_r})) >>> 32);
        acc = clip(acc, -lim, lim);
        err_int[i] = acc[31:0];
        r[i] = r[i] + ((e[i] * $signed({32'b0, prop_gain_r})) >>> 16) + acc;
      end
    end
    for (int i = 0; i < 3; i++) begin
      t = r[i] * hi + ((r[i] * lo) >>> 16);
      h[i] = clip(t >>> 16, -(64'sd1 <<< 28), 64'sd1 <<< 28);
    end
    nq[0] = q[0] + ((-q[1] * h[0] - q[2] * h[1] - q[3] * h[2]) >>> 30);
    nq[1] = q[1] + ((q[0] * h[0] + q[2] * h[2] - q[3] * h[1]) >>> 30);
    nq[2] = q[2] + ((q[0] * h[1] - q[1] * h[2] + q[3] * h[0]) >>> 30);
    nq[3] = q[3] + ((q[0] * h[2] + q[1] * h[1] - q[2] * h[0]) >>> 30);
    s = 0;
    for (int i = 0; i < 4; i++) s = s + nq[i] * nq[i];
    if (s == 0) begin
      att_q[0] = one[31:0];
      for (int i = 1; i < 4; i++) att_q[i] = '0;
    end else begin
      y = inv_root(s, k);
      for (int i = 0; i < 4; i++) begin
        t = clip((nq[i] * y) >>> (QN_BASE_SHIFT - k), -one, one);
        att_q[i] = t[31:0];
      end
    end
    o.quat_w = att_q[0] <<< OUT_SHIFT;
    o.quat_x = att_q[1] <<< OUT_SHIFT;
    o.quat_y = att_q[2] <<< OUT_SHIFT;
    o.quat_z = att_q[3] <<< OUT_SHIFT;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, n_results);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_quats.push_back(predict_quat(in_data_i));
        pending_samples.pop_front();
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_samples.size() > 0 && !hold_input &&
            $urandom_range(99) >= in_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_samples[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
      if (out_valid_o && !out_stall_i) begin
        if (expected_quats.size() == 0) begin
          report_mismatch("unexpected result", '0, '0);
        end else begin
          if (out_data_o.quat_w !== expected_quats[0].quat_w)
            report_mismatch("quat_w", out_data_o.quat_w, expected_quats[0].quat_w);
          if (out_data_o.quat_x !== expected_quats[0].quat_x)
            report_mismatch("quat_x", out_data_o.quat_x, expected_quats[0].quat_x);
          if (out_data_o.quat_y !== expected_quats[0].quat_y)
            report_mismatch("quat_y", out_data_o.quat_y, expected_quats[0].quat_y);
          if (out_data_o.quat_z !== expected_quats[0].quat_z)
            report_mismatch("quat_z", out_data_o.quat_z, expected_quats[0].quat_z);
          if (out_data_o.accel_valid !== expected_quats[0].accel_valid)
            report_mismatch("accel_valid", 32'(out_data_o.accel_valid),
                            32'(expected_quats[0].accel_valid));
          if (!expected_quats[0].accel_valid) n_no_accel++;
          expected_quats.pop_front();
        end
        n_results++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL mahony_attitude_update");
      $finish;
    end
  end

  task automatic write_reg(input mau_cfg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_GYRO_SCALE:     gyro_scale_r = val;
      CFG_PROP_GAIN:      prop_gain_r = val;
      CFG_INTEGRAL_GAIN:  int_gain_r = val;
      CFG_INTEGRAL_LIMIT: int_limit_r = {1'b0, val[30:0]};
      CFG_HALF_STEP:      half_step_r = val;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [31:0] gs, kp, ki, lim, hs);
    write_reg(CFG_GYRO_SCALE, gs);
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEGRAL_GAIN, ki);
    write_reg(CFG_INTEGRAL_LIMIT, lim);
    write_reg(CFG_HALF_STEP, hs);
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_samples.size() > 0 || in_valid_i || expected_quats.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_sample(input logic [15:0] gx, gy, gz, ax, ay, az);
    mau_in_t smp;
    smp.gyro_x = gx; smp.gyro_y = gy; smp.gyro_z = gz;
    smp.accel_x = ax; smp.accel_y = ay; smp.accel_z = az;
    pending_samples.push_back(smp);
  endtask

  task automatic push_random(input int n);
    mau_in_t smp;
    for (int i = 0; i < n; i++) begin
      smp = mau_in_t'({$urandom, $urandom, $urandom});
      case ($urandom_range(9))
        0, 1: ;
        2: begin
          smp.accel_x = '0; smp.accel_y = '0; smp.accel_z = '0;
        end
        default: begin
          smp.gyro_x = 16'($signed($urandom_range(4000)) - 2000);
          smp.gyro_y = 16'($signed($urandom_range(4000)) - 2000);
          smp.gyro_z = 16'($signed($urandom_range(4000)) - 2000);
          smp.accel_x = 16'($signed($urandom_range(4000)) - 2000);
          smp.accel_y = 16'($signed($urandom_range(4000)) - 2000);
          smp.accel_z = 16'($signed($urandom_range(4000)) + 14000);
        end
      endcase
      pending_samples.push_back(smp);
    end
  endtask

  initial begin
    gyro_scale_r = 32'd572220;
    prop_gain_r = 32'd131072;
    int_gain_r = 32'd0;
    int_limit_r = 32'd536870912;
    half_step_r = 32'd21474836;
    att_q[0] = 32'sd1 <<< QUAT_FRAC_BITS;
    att_q[1] = '0; att_q[2] = '0; att_q[3] = '0;
    for (int i = 0; i < 3; i++) err_int[i] = '0;
    in_idle_pct = 38;
    out_idle_pct = 50;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
    push_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    push_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    push_sample(16'h7fff, 16'h8000, 16'h0001, 16'h0001, 16'h0000, 16'h0000);
    push_sample(16'hffff, 16'h0000, 16'h7fff, 16'h0000, 16'hffff, 16'h0000);
    push_sample(16'h1234, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0001);
    push_sample(16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000);
    wait_quiet();

    set_all(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h7fffffff, 32'hffffffff);
    push_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'h0000);
    push_sample(16'h8000, 16'h7fff, 16'h8000, 16'h0100, 16'h8000, 16'h0001);
    push_sample(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h0000);
    push_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    wait_quiet();

    set_all(32'd572220, 32'd131072, 32'h40000000, 32'd1000, 32'd21474836);
    push_sample(16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000);
    push_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h0000);
    push_sample(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h0000);
    push_sample(16'h0100, 16'hff00, 16'h0080, 16'h0000, 16'h0000, 16'h0000);
    push_random(330);
    wait_quiet();

    set_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    in_idle_pct = 50;
    out_idle_pct = 38;
    push_random(60);
    wait_quiet();

    set_all(32'h0080_0000, 32'h0004_0000, 32'h0100_0000, 32'h7fffffff, 32'h0400_0000);
    push_random(150);
    do @(posedge clk_i); while (pending_samples.size() > 0);
    hold_input = 1'b1;
    do @(posedge clk_i); while (in_valid_i || expected_quats.size() > 0);
    hold_input = 1'b0;
    push_random(150);
    wait_quiet();

    set_all(32'd572220, 32'd65536, 32'd4294967, 32'd536870912, 32'd21474836);
    in_idle_pct = 0;
    out_idle_pct = 0;
    push_random(400);
    wait_quiet();

    $display("run covered %0d attitude updates, %0d without accel correction, %0d cycles",
             n_results, n_no_accel, cycles);
    $display("register sets: defaults, all-max, all-zero, strong integral, nominal");
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("PASS mahony_attitude_update");
    end else begin
      $display("FAIL mahony_attitude_update");
    end
    $finish;
  end

endmodule
